[hdl/sdrk_pkg.sv]
// Shared types and constants of the symmetric Dirichlet row kernel.
package sdrk_pkg;

  localparam logic [63:0] Max63  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinMag = 64'h8000_0000_0000_0000;
  localparam logic [63:0] OneQ32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] UMax   = 64'hFFFF_FFFF_FFFF_FFFF;

  // One closed row as it travels from the front to the back.
  typedef struct packed {
    logic signed [63:0] acc_re;
    logic signed [63:0] acc_im;
    logic [30:0]        weight;
    logic               last_row;
    logic               ovf;
  } row_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CONV = 7'b0000010,
    S_LOAD = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_MSAT = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } back_state_e;

  typedef enum logic [3:0] {
    ST_P, ST_Q, ST_DIV, ST_INV2, ST_INV3, ST_EN, ST_FW, ST_INRE, ST_INIM,
    ST_WA, ST_SQIM, ST_CB, ST_HBRE, ST_HBIM
  } step_e;

endpackage

[hdl/sdrk_in_if.sv]
// Input channel of the row kernel: one basis entry and coefficient per item.
interface sdrk_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] basis_re;
  logic signed [31:0] basis_im;
  logic signed [31:0] coef_re;
  logic signed [31:0] coef_im;
  logic [30:0]        weight;
  logic               row_end;
  logic               last_row;

  modport source(output valid, basis_re, basis_im, coef_re, coef_im, weight, row_end,
                 last_row, input ready);
  modport sink(input valid, basis_re, basis_im, coef_re, coef_im, weight, row_end,
               last_row, output ready);
endinterface

[hdl/sdrk_out_if.sv]
// Result channel of the row kernel: one item per closed row.
interface sdrk_out_if;
  logic               valid;
  logic               ready;
  logic [62:0]        energy_term;
  logic signed [63:0] inner_re;
  logic signed [63:0] inner_im;
  logic [62:0]        hess_a_weight;
  logic signed [63:0] hess_b_re;
  logic signed [63:0] hess_b_im;
  logic [62:0]        energy_sum;
  logic               sum_valid;
  logic               saturated;

  modport source(output valid, energy_term, inner_re, inner_im, hess_a_weight, hess_b_re,
                 hess_b_im, energy_sum, sum_valid, saturated, input ready);
  modport sink(input valid, energy_term, inner_re, inner_im, hess_a_weight, hess_b_re,
               hess_b_im, energy_sum, sum_valid, saturated, output ready);
endinterface

[hdl/sdrk_front.sv]
// Front end: complex multiply-accumulate of the derivative, pushes closed rows.
module sdrk_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  sdrk_in_if.sink       in_i,
  input  logic          space_ok_i,
  output logic          push_o,
  output sdrk_pkg::row_t push_data_o
);

  function automatic logic [64:0] sadd(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
    logic signed [63:0] r;
    logic               ov;
    r  = a + b;
    ov = (a[63] == b[63]) && (r[63] != a[63]);
    if (ov) r = a[63] ? sdrk_pkg::MinMag : sdrk_pkg::Max63;
    return {ov, r};
  endfunction

  logic               a_valid_q, a_end_q, a_last_q;
  logic [30:0]        a_w_q;
  logic signed [63:0] rr_q, ii_q, ri_q, ir_q;
  logic signed [63:0] acc_re_q, acc_im_q;
  logic               row_ovf_q;

  logic [64:0]        re1, re2, im1, im2;
  logic               step_ovf;

  assign in_i.ready = space_ok_i;

  always_comb begin
    re1 = sadd(acc_re_q, rr_q);
    re2 = sadd(re1[63:0], -ii_q);
    im1 = sadd(acc_im_q, ri_q);
    im2 = sadd(im1[63:0], ir_q);
    step_ovf = re1[64] | re2[64] | im1[64] | im2[64];
  end

  assign push_o = a_valid_q & a_end_q;
  assign push_data_o = '{acc_re: re2[63:0], acc_im: im2[63:0], weight: a_w_q,
                         last_row: a_last_q, ovf: row_ovf_q | step_ovf};

  always_ff @(posedge clk_i) begin
    rr_q     <= 64'(in_i.basis_re) * 64'(in_i.coef_re);
    ii_q     <= 64'(in_i.basis_im) * 64'(in_i.coef_im);
    ri_q     <= 64'(in_i.basis_re) * 64'(in_i.coef_im);
    ir_q     <= 64'(in_i.basis_im) * 64'(in_i.coef_re);
    a_end_q  <= in_i.row_end;
    a_last_q <= in_i.last_row;
    a_w_q    <= in_i.weight;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      acc_re_q  <= '0;
      acc_im_q  <= '0;
      row_ovf_q <= 1'b0;
    end else begin
      a_valid_q <= in_i.valid & in_i.ready;
      if (a_valid_q) begin
        if (a_end_q) begin
          acc_re_q  <= '0;
          acc_im_q  <= '0;
          row_ovf_q <= 1'b0;
        end else begin
          acc_re_q  <= re2[63:0];
          acc_im_q  <= im2[63:0];
          row_ovf_q <= row_ovf_q | step_ovf;
        end
      end
    end
  end

endmodule

[hdl/sdrk_fifo.sv]
// Short row queue between the front and the back.
module sdrk_fifo #(
  parameter int Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdrk_pkg::row_t data_i,
  input  logic           pop_i,
  output sdrk_pkg::row_t data_o,
  output logic           empty_o,
  output logic           space_ok_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  sdrk_pkg::row_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  // Room for one more row beyond the one that may sit in the product stage.
  assign space_ok_o = (cnt_q < CntW'(Depth - 1));

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

[hdl/sdrk_mul.sv]
// Shared 64 by 64 unsigned multiplier, one 32 by 32 partial product per cycle.
module sdrk_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  output logic          done_o,
  output logic [127:0]  prod_o
);

  logic [63:0]  a_q, b_q;
  logic [1:0]   cnt_q;
  logic         busy_q, done_q;
  logic [127:0] acc_q;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_ext;

  always_comb begin
    ah = cnt_q[0] ? a_q[63:32] : a_q[31:0];
    bh = cnt_q[1] ? b_q[63:32] : b_q[31:0];
    pp = 64'(ah) * 64'(bh);
    unique case (cnt_q)
      2'd0:    pp_ext = {64'd0, pp};
      2'd3:    pp_ext = {pp, 64'd0};
      default: pp_ext = {32'd0, pp, 32'd0};
    endcase
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/sdrk_back.sv]
// Back end: per-row sequencer for magnitude, reciprocal and the weighted results.
module sdrk_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           min_square_we_i,
  input  logic [32:0]    min_square_i,
  input  sdrk_pkg::row_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  sdrk_out_if.source     out_o
);

  localparam int Up  = 32 - 2 * FRAC_BITS;
  localparam int ShL = (Up > 0) ? Up : 0;
  localparam int ShR = (Up < 0) ? -Up : 0;
  localparam logic [5:0] ShF  = 6'(FRAC_BITS);
  localparam logic [5:0] ShF1 = 6'(FRAC_BITS - 1);
  localparam logic [5:0] ShF2 = 6'(FRAC_BITS - 2);

  sdrk_pkg::back_state_e state_q;
  sdrk_pkg::step_e       step_q;
  sdrk_pkg::row_t        ent_q;

  logic [32:0]        min_sq_q;
  logic signed [63:0] fr_q, fi_q;
  logic [63:0]        p_q, q_q, s_q, inv_q, inv2_q, inv3_q;
  logic [62:0]        energy_q, wa_q, cb_q, total_q;
  logic signed [63:0] fw_q, inre_q, inim_q, sqim_q, hbre_q, hbim_q;
  logic               ovf_q, gt_q;
  logic [5:0]         sh_q;
  logic [63:0]        lim_q, div_m_q, rem_q, quo_q;
  logic               neg_q;
  logic [6:0]         div_cnt_q;

  logic               ov_q;
  logic [62:0]        o_en_q, o_wa_q, o_sum_q;
  logic signed [63:0] o_inre_q, o_inim_q, o_hbre_q, o_hbim_q;
  logic               o_last_q, o_sat_q;

  // Conversion of the accumulators to Q32.32.
  logic signed [63:0] cv_re, cv_im, cv_lim;
  logic               cv_ovf;

  always_comb begin
    cv_lim = $signed(sdrk_pkg::Max63) >>> ShL;
    cv_ovf = 1'b0;
    if (Up >= 0) begin
      if (ent_q.acc_re > cv_lim) begin
        cv_re = sdrk_pkg::Max63; cv_ovf = 1'b1;
      end else if (ent_q.acc_re < -cv_lim - 64'sd1) begin
        cv_re = sdrk_pkg::MinMag; cv_ovf = 1'b1;
      end else begin
        cv_re = ent_q.acc_re <<< ShL;
      end
      if (ent_q.acc_im > cv_lim) begin
        cv_im = sdrk_pkg::Max63; cv_ovf = 1'b1;
      end else if (ent_q.acc_im < -cv_lim - 64'sd1) begin
        cv_im = sdrk_pkg::MinMag; cv_ovf = 1'b1;
      end else begin
        cv_im = ent_q.acc_im <<< ShL;
      end
    end else begin
      cv_re = ent_q.acc_re >>> ShR;
      cv_im = ent_q.acc_im >>> ShR;
    end
  end

  logic [63:0] fr_mag, fi_mag, fw_mag, sqim_mag, w64, cb64, mn64, m_sel;
  assign fr_mag   = fr_q[63] ? 64'd0 - fr_q : fr_q;
  assign fi_mag   = fi_q[63] ? 64'd0 - fi_q : fi_q;
  assign fw_mag   = fw_q[63] ? 64'd0 - fw_q : fw_q;
  assign sqim_mag = sqim_q[63] ? 64'd0 - sqim_q : sqim_q;
  assign w64      = {33'd0, ent_q.weight};
  assign cb64     = {1'b0, cb_q};
  assign mn64     = (min_sq_q == '0) ? 64'd1 : {31'd0, min_sq_q};
  assign m_sel    = (s_q > mn64) ? s_q : mn64;

  // Operands of the multiply that the current step needs.
  logic [63:0] op_a, op_b, op_lim;
  logic [5:0]  op_sh;
  logic        op_neg, op_ovf;
  logic [64:0] sum_en, gam;
  logic [63:0] fac_d, sq_d;

  always_comb begin
    op_a = '0; op_b = '0; op_sh = 6'd32; op_lim = sdrk_pkg::UMax;
    op_neg = 1'b0; op_ovf = 1'b0;
    sum_en = {1'b0, s_q} + {1'b0, inv_q};
    gam    = {1'b0, sdrk_pkg::OneQ32} + {1'b0, inv2_q};
    fac_d  = inv2_q - sdrk_pkg::OneQ32;
    sq_d   = (p_q >= q_q) ? p_q - q_q : q_q - p_q;
    unique case (step_q)
      sdrk_pkg::ST_P: begin op_a = fr_mag; op_b = fr_mag; end
      sdrk_pkg::ST_Q: begin op_a = fi_mag; op_b = fi_mag; end
      sdrk_pkg::ST_INV2: begin op_a = inv_q; op_b = inv_q; end
      sdrk_pkg::ST_INV3: begin op_a = inv2_q; op_b = inv_q; end
      sdrk_pkg::ST_EN: begin
        op_a = w64; op_b = sum_en[64] ? sdrk_pkg::UMax : sum_en[63:0];
        op_ovf = sum_en[64]; op_sh = ShF; op_lim = sdrk_pkg::Max63;
      end
      sdrk_pkg::ST_FW: begin
        op_b = w64; op_sh = ShF;
        if (inv2_q <= sdrk_pkg::OneQ32) begin
          op_a = sdrk_pkg::OneQ32 - inv2_q;
        end else if (fac_d > sdrk_pkg::MinMag) begin
          op_a = sdrk_pkg::MinMag; op_neg = 1'b1; op_ovf = 1'b1;
        end else begin
          op_a = fac_d; op_neg = 1'b1;
        end
        op_lim = op_neg ? sdrk_pkg::MinMag : sdrk_pkg::Max63;
      end
      sdrk_pkg::ST_INRE: begin
        op_a = fw_mag; op_b = fr_mag; op_neg = fw_q[63] ^ fr_q[63];
        op_lim = op_neg ? sdrk_pkg::MinMag : sdrk_pkg::Max63;
      end
      sdrk_pkg::ST_INIM: begin
        op_a = fw_mag; op_b = fi_mag; op_neg = fw_q[63] ^ fi_q[63];
        op_lim = op_neg ? sdrk_pkg::MinMag : sdrk_pkg::Max63;
      end
      sdrk_pkg::ST_WA: begin
        op_a = gam[64] ? sdrk_pkg::UMax : gam[63:0]; op_ovf = gam[64];
        op_b = w64; op_sh = ShF1; op_lim = sdrk_pkg::Max63;
      end
      sdrk_pkg::ST_SQIM: begin
        op_a = fr_mag; op_b = fi_mag; op_neg = fr_q[63] ^ fi_q[63]; op_sh = 6'd31;
        op_lim = op_neg ? sdrk_pkg::MinMag : sdrk_pkg::Max63;
      end
      sdrk_pkg::ST_CB: begin
        op_a = inv3_q; op_b = w64; op_sh = ShF2; op_lim = sdrk_pkg::Max63;
      end
      sdrk_pkg::ST_HBRE: begin
        op_a = cb64;
        if (p_q >= q_q) begin
          op_b = (sq_d > sdrk_pkg::Max63) ? sdrk_pkg::Max63 : sq_d;
          op_ovf = (sq_d > sdrk_pkg::Max63);
        end else begin
          op_neg = 1'b1;
          op_b = (sq_d > sdrk_pkg::MinMag) ? sdrk_pkg::MinMag : sq_d;
          op_ovf = (sq_d > sdrk_pkg::MinMag);
        end
        op_lim = op_neg ? sdrk_pkg::MinMag : sdrk_pkg::Max63;
      end
      sdrk_pkg::ST_HBIM: begin
        op_a = cb64; op_b = sqim_mag; op_neg = sqim_q[63];
        op_lim = op_neg ? sdrk_pkg::MinMag : sdrk_pkg::Max63;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  logic         mul_start, mul_done;
  logic [127:0] mul_prod;

  assign mul_start = (state_q == sdrk_pkg::S_LOAD) && (step_q != sdrk_pkg::ST_DIV);

  sdrk_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Shift and saturation of the finished product.
  logic [127:0]       shifted;
  logic               msat;
  logic [63:0]        mag;
  logic signed [63:0] res_s;
  logic [64:0]        s_sum;

  always_comb begin
    shifted = mul_prod >> sh_q;
    msat    = (shifted[127:64] != '0) || (shifted[63:0] > lim_q);
    mag     = msat ? lim_q : shifted[63:0];
    res_s   = neg_q ? 64'd0 - mag : mag;
    s_sum   = {1'b0, p_q} + {1'b0, mag};
  end

  // Divider step: restoring division of 2^64 by m, one quotient bit a cycle.
  logic [64:0] rem2;
  logic        div_ge;
  assign rem2   = {rem_q, (div_cnt_q == 7'd64)};
  assign div_ge = rem2 >= {1'b0, div_m_q};

  logic [63:0] tot;
  logic        out_free;
  assign tot      = {1'b0, total_q} + {1'b0, energy_q};
  assign out_free = !ov_q || out_o.ready;

  assign pop_o = (state_q == sdrk_pkg::S_IDLE) && !empty_i;

  assign out_o.valid         = ov_q;
  assign out_o.energy_term   = o_en_q;
  assign out_o.inner_re      = o_inre_q;
  assign out_o.inner_im      = o_inim_q;
  assign out_o.hess_a_weight = o_wa_q;
  assign out_o.hess_b_re     = o_hbre_q;
  assign out_o.hess_b_im     = o_hbim_q;
  assign out_o.energy_sum    = o_sum_q;
  assign out_o.sum_valid     = o_last_q;
  assign out_o.saturated     = o_sat_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= head_i;
    if (state_q == sdrk_pkg::S_CONV) begin
      fr_q <= cv_re;
      fi_q <= cv_im;
    end
    if (mul_start) begin
      sh_q  <= op_sh;
      lim_q <= op_lim;
      neg_q <= op_neg;
    end
    if ((state_q == sdrk_pkg::S_LOAD) && (step_q == sdrk_pkg::ST_DIV)) begin
      div_m_q <= m_sel;
      gt_q    <= s_q > mn64;
    end
    if (state_q == sdrk_pkg::S_MSAT) begin
      unique case (step_q)
        sdrk_pkg::ST_P:    p_q <= mag;
        sdrk_pkg::ST_Q: begin
          q_q <= mag;
          s_q <= s_sum[64] ? sdrk_pkg::UMax : s_sum[63:0];
        end
        sdrk_pkg::ST_INV2: inv2_q <= mag;
        sdrk_pkg::ST_INV3: inv3_q <= mag;
        sdrk_pkg::ST_EN:   energy_q <= mag[62:0];
        sdrk_pkg::ST_FW:   fw_q <= res_s;
        sdrk_pkg::ST_INRE: inre_q <= res_s;
        sdrk_pkg::ST_INIM: inim_q <= res_s;
        sdrk_pkg::ST_WA:   wa_q <= mag[62:0];
        sdrk_pkg::ST_SQIM: sqim_q <= res_s;
        sdrk_pkg::ST_CB:   cb_q <= mag[62:0];
        sdrk_pkg::ST_HBRE: hbre_q <= res_s;
        sdrk_pkg::ST_HBIM: hbim_q <= res_s;
        default:           p_q <= p_q;
      endcase
    end
    if ((state_q == sdrk_pkg::S_LOAD) && (step_q == sdrk_pkg::ST_DIV)) begin
      rem_q <= '0;
      if (m_sel <= 64'd1) inv_q <= sdrk_pkg::UMax;
      if (!(s_q > mn64)) begin
        inv2_q <= '0;
        inv3_q <= '0;
      end
    end else if (state_q == sdrk_pkg::S_DIV) begin
      rem_q <= div_ge ? 64'(rem2 - {1'b0, div_m_q}) : rem2[63:0];
      quo_q <= {quo_q[62:0], div_ge};
      if (div_cnt_q == 7'd0) begin
        inv_q <= {quo_q[62:0], div_ge};
        if (!gt_q) begin
          inv2_q <= '0;
          inv3_q <= '0;
        end
      end
    end
    if ((state_q == sdrk_pkg::S_FIN) && out_free) begin
      o_en_q   <= energy_q;
      o_inre_q <= inre_q;
      o_inim_q <= inim_q;
      o_wa_q   <= wa_q;
      o_hbre_q <= hbre_q;
      o_hbim_q <= hbim_q;
      o_sum_q  <= ent_q.last_row ? (tot[63] ? sdrk_pkg::Max63[62:0] : tot[62:0]) : '0;
      o_last_q <= ent_q.last_row;
      o_sat_q  <= ovf_q | tot[63];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sdrk_pkg::S_IDLE;
      step_q    <= sdrk_pkg::ST_P;
      min_sq_q  <= 33'd1;
      ovf_q     <= 1'b0;
      total_q   <= '0;
      ov_q      <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      if (min_square_we_i) min_sq_q <= min_square_i;
      if ((state_q == sdrk_pkg::S_FIN) && out_free) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        sdrk_pkg::S_IDLE: begin
          if (!empty_i) state_q <= sdrk_pkg::S_CONV;
        end
        sdrk_pkg::S_CONV: begin
          ovf_q   <= ovf_q | ent_q.ovf | cv_ovf;
          step_q  <= sdrk_pkg::ST_P;
          state_q <= sdrk_pkg::S_LOAD;
        end
        sdrk_pkg::S_LOAD: begin
          if (step_q == sdrk_pkg::ST_DIV) begin
            if (m_sel <= 64'd1) begin
              // A floor of one with s at most one: the reciprocal saturates.
              ovf_q  <= 1'b1;
              step_q <= sdrk_pkg::ST_EN;
            end else begin
              div_cnt_q <= 7'd64;
              state_q   <= sdrk_pkg::S_DIV;
            end
          end else begin
            ovf_q   <= ovf_q | op_ovf;
            state_q <= sdrk_pkg::S_MUL;
          end
        end
        sdrk_pkg::S_MUL: begin
          if (mul_done) state_q <= sdrk_pkg::S_MSAT;
        end
        sdrk_pkg::S_MSAT: begin
          ovf_q <= ovf_q | msat | ((step_q == sdrk_pkg::ST_Q) & s_sum[64]);
          if (step_q == sdrk_pkg::ST_HBIM) begin
            state_q <= sdrk_pkg::S_FIN;
          end else begin
            step_q  <= sdrk_pkg::step_e'(step_q + 4'd1);
            state_q <= sdrk_pkg::S_LOAD;
          end
        end
        sdrk_pkg::S_DIV: begin
          div_cnt_q <= div_cnt_q - 7'd1;
          if (div_cnt_q == 7'd0) begin
            step_q  <= gt_q ? sdrk_pkg::ST_INV2 : sdrk_pkg::ST_EN;
            state_q <= sdrk_pkg::S_LOAD;
          end
        end
        sdrk_pkg::S_FIN: begin
          if (out_free) begin
            state_q <= sdrk_pkg::S_IDLE;
            if (ent_q.last_row) begin
              total_q <= '0;
              ovf_q   <= 1'b0;
            end else begin
              total_q <= tot[63] ? sdrk_pkg::Max63[62:0] : tot[62:0];
              ovf_q   <= ovf_q | tot[63];
            end
          end
        end
        default: state_q <= sdrk_pkg::S_IDLE;
      endcase
    end
  end

endmodule

[hdl/symmetric_dirichlet_row_kernel.sv]
// Symmetric Dirichlet row kernel: top level joining front, row queue and back.
// The front takes one basis/coefficient item per cycle as long as the row queue
// has room, so rows are streamed at full rate. Each row_end item produces one
// result; the back works one row at a time, its pace set by the shared 32x32
// partial-product multiplier (up to 13 multiplies per row) and the
// one-bit-per-cycle reciprocal divider. Short rows therefore fill the
// QUEUE_DEPTH-entry queue and then hold off the input.
// min_square is taken whenever its write enable is high.
module symmetric_dirichlet_row_kernel #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        min_square_we_i,
  input  logic [32:0] min_square_i,
  sdrk_in_if.sink     in_i,
  sdrk_out_if.source  out_o
);

  logic           push, pop, empty, space_ok;
  sdrk_pkg::row_t push_data, head;

  sdrk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .space_ok_i  (space_ok),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sdrk_fifo #(.Depth(QUEUE_DEPTH)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (push_data),
    .pop_i      (pop),
    .data_o     (head),
    .empty_o    (empty),
    .space_ok_o (space_ok)
  );

  sdrk_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .min_square_we_i (min_square_we_i),
    .min_square_i    (min_square_i),
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_o           (out_o)
  );

endmodule
